/* rtl/povb_pkg.sv */
`timescale 1ns / 1ps
package povb_pkg;

    localparam int Voices     = 5;
    localparam int VoiceBits  = 3;
    localparam int SineBits   = 10;
    localparam int TableSize  = 1 << SineBits;
    localparam int QBits      = SineBits - 2;
    localparam int GainMax    = 32767;
    localparam int WaveAmp    = 9830;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ON   = 2'd1,
        OP_OFF  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        WAVE_SINE = 2'd0,
        WAVE_SAW  = 2'd1,
        WAVE_SQR  = 2'd2,
        WAVE_NONE = 2'd3
    } t_wave;

    typedef enum logic [1:0] {
        REG_ATTACK    = 2'd0,
        REG_DECAY     = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_CEILING   = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MULT,
        ST_DONE
    } t_state;

    // classified command handed from the front to the back
    typedef struct packed {
        t_op         op;
        logic [30:0] step;
        logic [14:0] gain;
        logic [1:0]  wave;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [2:0]         voice_count;
        logic               accepted;
    } t_res;

    // quarter sine polynomial, only called with constant arguments for the table
    function automatic logic [14:0] quarter_sine(input logic [15:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        begin
            x2 = (64'(x) * 64'(x)) >> 15;
            p  = 64'd21024 - ((x2 * 64'd2320) >> 15);
            p  = 64'd51472 - ((x2 * p) >> 15);
            p  = (64'(x) * p) >> 15;
            quarter_sine = (p > 64'(GainMax)) ? 15'(GainMax) : p[14:0];
        end
    endfunction

endpackage

/* rtl/povb_if.sv */
`timescale 1ns / 1ps
interface povb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [30:0] phase_step;
    logic [6:0]  velocity;
    logic [1:0]  wave;
    modport source (output valid, op, phase_step, velocity, wave, input ready);
    modport sink   (input valid, op, phase_step, velocity, wave, output ready);
endinterface

interface povb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [2:0]         voice_count;
    logic               accepted;
    modport source (output valid, sample, voice_count, accepted, input ready);
    modport sink   (input valid, sample, voice_count, accepted, output ready);
endinterface

/* rtl/povb_front.sv */
`timescale 1ns / 1ps
module povb_front import povb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [30:0] i_step,
    input  logic [6:0]  i_velocity,
    input  logic [1:0]  i_wave,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop,
    output t_cmd        o_cmd
);
    t_cmd        r_q [QueueDepth];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic [21:0] vel_prod;
    logic [14:0] start_gain;
    t_cmd        cmd_in;
    logic        push;

    // starting gain: (v*32767+63)/127 == v*258 + (v >= 64) for v in 0..127
    assign vel_prod   = 22'(i_velocity) * 22'd258;
    assign start_gain = vel_prod[14:0] + 15'(i_velocity[6]);

    always_comb begin
        cmd_in.op   = t_op'(i_op);
        cmd_in.step = i_step;
        cmd_in.gain = start_gain;
        cmd_in.wave = i_wave;
    end

    assign o_ready     = (r_cnt != 2'(QueueDepth));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    // command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd_in;
    end
endmodule

/* rtl/povb_back.sv */
`timescale 1ns / 1ps
module povb_back import povb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  t_cmd        i_cmd,
    input  logic [16:0] i_attack,
    input  logic [14:0] i_decay,
    input  logic [14:0] i_threshold,
    input  logic [14:0] i_ceiling,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_res        o_res
);
    t_state r_state, n_state;

    logic [Voices-1:0] r_valid, r_rel;
    logic [31:0]       r_phase [Voices];
    logic [30:0]       r_step  [Voices];
    logic [14:0]       r_gain  [Voices];
    logic [1:0]        r_wave  [Voices];

    logic [VoiceBits-1:0] r_idx;
    logic signed [19:0]   r_mix;
    logic                 r_acc;
    logic signed [16:0]   r_wv;
    logic                 r_out_v;
    t_res                 r_res;

    logic signed [16:0] wv;
    logic signed [32:0] term;
    logic signed [17:0] term_s;
    logic [31:0]        env_prod;
    logic [31:0]        env_sel;
    logic [14:0]        new_gain;
    logic               last;
    logic               take;
    logic               st_idle, st_scan, st_mult, st_done;
    logic [Voices-1:0]  match;
    logic [Voices-1:0]  free_v;
    logic               dup;
    logic [VoiceBits-1:0] free_idx;
    logic               has_free;
    logic signed [19:0] mix_fin;
    logic [2:0]         cnt;
    logic [31:0]        ph;
    logic signed [15:0] saw_s;
    logic signed [31:0] saw_p;
    logic [14:0]        qsin_tab [1 << QBits];
    logic [SineBits-1:0] sk;
    logic [QBits:0]     qi;
    logic [14:0]        qy;
    logic signed [16:0] sine_v;

    // a command starts once the result register is free or being emptied
    assign take = i_cmd_valid && (!r_out_v || i_res_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (take)
                         n_state = (i_cmd.op == OP_TICK) ? ST_SCAN : ST_DONE;
            ST_SCAN: n_state = ST_MULT;
            ST_MULT: n_state = last ? ST_DONE : ST_SCAN;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        st_idle = 1'b0; st_scan = 1'b0; st_mult = 1'b0; st_done = 1'b0;
        unique case (r_state)
            ST_IDLE: st_idle = 1'b1;
            ST_SCAN: st_scan = 1'b1;
            ST_MULT: st_mult = 1'b1;
            ST_DONE: st_done = 1'b1;
            default: st_idle = 1'b1;
        endcase
    end

    assign last      = (r_idx == VoiceBits'(Voices - 1));
    assign o_cmd_pop = st_done;

    // quarter sine table, constant entries
    for (genvar j = 0; j < (1 << QBits); j++) begin : g_qsin
        assign qsin_tab[j] = quarter_sine(16'(j << (15 - QBits)));
    end

    // full sine from the quarter table, mirrored by quadrant
    assign ph = r_phase[r_idx];
    assign sk = ph[31 -: SineBits];
    assign qi = sk[SineBits-2] ? ((QBits+1)'(1 << QBits) - {1'b0, sk[QBits-1:0]})
                               : {1'b0, sk[QBits-1:0]};
    assign qy = qi[QBits] ? 15'(GainMax) : qsin_tab[qi[QBits-1:0]];
    assign sine_v = sk[SineBits-1] ? -$signed({2'b00, qy}) : $signed({2'b00, qy});

    // wave value of the voice at r_idx
    assign saw_s = $signed(ph[31:16]);
    assign saw_p = 32'(saw_s) * 32'sd9830;
    always_comb begin
        case (t_wave'(r_wave[r_idx]))
            WAVE_SINE: wv = sine_v;
            WAVE_SAW:  wv = 17'(saw_p >>> 15);
            WAVE_SQR:  wv = (ph[30:0] == 31'd0) ? 17'sd0 :
                            (ph[31] ? -17'sd9830 : 17'sd9830);
            default:   wv = 17'sd0;
        endcase
    end

    // gain times wave, floor shift
    assign term   = $signed({1'b0, r_gain[r_idx]}) * r_wv;
    assign term_s = 18'(term >>> 15);

    // envelope update
    assign env_sel  = r_rel[r_idx] ? 32'(i_decay) : 32'(i_attack);
    assign env_prod = 32'(r_gain[r_idx]) * env_sel;
    always_comb begin
        new_gain = r_gain[r_idx];
        if (r_rel[r_idx]) new_gain = env_prod[29:15];
        else if (r_gain[r_idx] <= i_ceiling)
            new_gain = (env_prod[31:15] > 17'(GainMax)) ? 15'(GainMax)
                                                         : env_prod[29:15];
    end

    // note matching
    always_comb begin
        dup = 1'b0; has_free = 1'b0; free_idx = '0;
        for (int i = 0; i < Voices; i++) begin
            match[i]  = r_valid[i] && (r_step[i] == i_cmd.step);
            free_v[i] = !r_valid[i];
            if (match[i]) dup = 1'b1;
        end
        for (int i = Voices - 1; i >= 0; i--) begin
            if (free_v[i]) begin
                has_free = 1'b1;
                free_idx = VoiceBits'(i);
            end
        end
    end

    always_comb begin
        cnt = '0;
        for (int i = 0; i < Voices; i++) cnt = cnt + 3'(r_valid[i]);
    end

    assign mix_fin = (r_mix > 20'sd32767) ? 20'sd32767 :
                     (r_mix < -20'sd32768) ? -20'sd32768 : r_mix;

    // control and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_rel   <= '0;
            r_out_v <= 1'b0;
            r_idx   <= '0;
            for (int i = 0; i < Voices; i++) r_phase[i] <= '0;
        end else begin
            r_state <= n_state;
            if (o_res_valid && i_res_ready) r_out_v <= 1'b0;
            if (st_idle) begin
                r_idx <= '0;
                r_mix <= '0;
                r_acc <= 1'b0;
                if (take && i_cmd.op == OP_ON && !dup && has_free) begin
                    r_valid[free_idx] <= 1'b1;
                    r_rel[free_idx]   <= 1'b0;
                    r_phase[free_idx] <= '0;
                    r_step[free_idx]  <= i_cmd.step;
                    r_gain[free_idx]  <= i_cmd.gain;
                    r_wave[free_idx]  <= i_cmd.wave;
                    r_acc             <= 1'b1;
                end
                if (take && i_cmd.op == OP_OFF) begin
                    r_rel <= r_rel | match;
                    r_acc <= |match;
                end
            end
            if (st_scan) r_wv <= wv;
            if (st_mult) begin
                if (r_valid[r_idx]) begin
                    r_mix          <= r_mix + 20'(term_s);
                    r_phase[r_idx] <= r_phase[r_idx] + {1'b0, r_step[r_idx]};
                    r_gain[r_idx]  <= new_gain;
                    if (new_gain < i_threshold) begin
                        r_valid[r_idx] <= 1'b0;
                        r_rel[r_idx]   <= 1'b0;
                    end
                end
                if (!last) r_idx <= r_idx + 1'b1;
            end
            if (st_done) begin
                r_out_v <= 1'b1;
                r_res.sample      <= (i_cmd.op == OP_TICK) ? mix_fin[15:0] : 16'sd0;
                r_res.voice_count <= cnt;
                r_res.accepted    <= (i_cmd.op == OP_TICK) ? 1'b0 : r_acc;
            end
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_res;
endmodule

/* rtl/poly_oscillator_voice_bank.sv */
`timescale 1ns / 1ps
// note commands pass from the idle state through the done state to the result;
// a tick loops over every voice: the wave in the scan state, mix and envelope in the mult state,
// and ends in the done state; a new command is taken only in idle once the result is free
// synchronous active-low reset clears voices, queue and the registers to
// attack 32800, decay 32700, threshold 33, ceiling 32767
module poly_oscillator_voice_bank import povb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    povb_in_if.sink     in_ch,
    povb_out_if.source  out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);
    logic [16:0] r_attack;
    logic [14:0] r_decay, r_threshold, r_ceiling;
    logic        cmd_valid, cmd_pop;
    t_cmd        cmd;
    t_res        res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= 17'd32800;
            r_decay     <= 15'd32700;
            r_threshold <= 15'd33;
            r_ceiling   <= 15'd32767;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_ATTACK:    r_attack    <= i_cfg_data;
                REG_DECAY:     r_decay     <= i_cfg_data[14:0];
                REG_THRESHOLD: r_threshold <= i_cfg_data[14:0];
                REG_CEILING:   r_ceiling   <= i_cfg_data[14:0];
                default:       r_attack    <= r_attack;
            endcase
        end
    end

    povb_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_op(in_ch.op), .i_step(in_ch.phase_step),
        .i_velocity(in_ch.velocity), .i_wave(in_ch.wave),
        .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd)
    );

    povb_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .i_cmd(cmd),
        .i_attack(r_attack), .i_decay(r_decay),
        .i_threshold(r_threshold), .i_ceiling(r_ceiling),
        .o_res_valid(out_ch.valid), .i_res_ready(out_ch.ready), .o_res(res)
    );

    assign out_ch.sample      = res.sample;
    assign out_ch.voice_count = res.voice_count;
    assign out_ch.accepted    = res.accepted;

    // count never exceeds the bank size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.voice_count <= 3'(Voices))
        else $error("voice count out of range");

    // a pop only happens with a queued command
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("pop from empty queue");

    // ticks never report accepted
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_pop && cmd.op == OP_TICK) |=> !res.accepted)
        else $error("tick flagged accepted");
endmodule
